// File: sv/char_lcd_shadow_diff_writer_core_defines.svh
// Assertion macros used by the shadow diff writer controller.
// Both expect signals named clock and reset in the enclosing module.
`ifndef CHAR_LCD_SHADOW_DIFF_WRITER_CORE_DEFINES_SVH
`define CHAR_LCD_SHADOW_DIFF_WRITER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define SDW_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Next-cycle implication, checked outside reset
`define SDW_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) pre |=> post) else $error(msg);

`endif

// File: sv/sdw_pkg.sv
package sdw_pkg;

   // Display geometry
   localparam int COLUMNS = 20;
   localparam int ROWS    = 4;

   localparam logic [7:0] SPACE_CHAR = 8'h20;

   // Column inside a row, offset counter (counts up to COLUMNS), start plus offset
   localparam int COL_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
   localparam int OFF_W  = $clog2(COLUMNS + 1);
   localparam int POS_W  = $clog2(2 * COLUMNS);
   localparam int DEPTH  = ROWS * COLUMNS;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // Command kinds on the result channel
   localparam logic KIND_CURSOR = 1'b0;
   localparam logic KIND_WRITE  = 1'b1;

   typedef struct packed {
      logic [2:0] row_index;
      logic [4:0] start_column;
      logic [7:0] char_code;
      logic       char_present;
      logic       force_write;
      logic       last_char;
   } req_item_type;

   typedef struct packed {
      logic       cmd_kind;
      logic [4:0] out_col;
      logic [1:0] out_row;
      logic [7:0] out_char;
      logic       last_of_item;
   } rsp_item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CMP,
      ST_SCAN,
      ST_CH_CUR,
      ST_CH_WR,
      ST_PAD_CUR,
      ST_PAD_SP
   } state_type;

   typedef enum logic [1:0] {
      SEL_CH_CUR,
      SEL_CH_WR,
      SEL_PAD_CUR,
      SEL_PAD_SP
   } out_sel_type;

   typedef struct packed {
      logic        accept;
      logic        compare;
      logic        scan_step;
      logic        load_out;
      out_sel_type out_sel;
   } cmd_type;

   typedef struct packed {
      logic changed_now;
      logic changed;
      logic need_cursor;
      logic last;
      logic in_range;
      logic any_pad;
      logic scan_busy;
      logic pad_end;
      logic out_free;
   } status_type;

endpackage

// File: sv/sdw_req_if.sv
interface sdw_req_if;
   logic                 valid;
   logic                 ready;
   sdw_pkg::req_item_type item;

   modport source (output valid, output item, input ready);
   modport sink   (input valid, input item, output ready);
endinterface

// File: sv/sdw_rsp_if.sv
interface sdw_rsp_if;
   logic                 valid;
   logic                 ready;
   sdw_pkg::rsp_item_type item;

   modport source (output valid, output item, input ready);
   modport sink   (input valid, input item, output ready);
endinterface

// File: sv/sdw_datapath.sv
module sdw_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  sdw_pkg::req_item_type req_item,
   input  sdw_pkg::cmd_type      cmd,
   output sdw_pkg::status_type   status,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output sdw_pkg::rsp_item_type rsp_item
);
   import sdw_pkg::*;

   // Shadow store and its written marks
   logic [7:0]       mem [0:DEPTH-1];
   logic [DEPTH-1:0] valid_ff, valid_in;
   logic [7:0]       mem_q_ff;
   logic             vld_q_ff;
   logic [7:0]       rd_data;

   // Control state
   logic [OFF_W-1:0] offset_ff, offset_in;
   logic             prev_ff, prev_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             scan_pend_ff, scan_pend_in;

   // Per-item working registers
   req_item_type      item_ff, item_in;
   logic              in_range_ff, in_range_in;
   logic              char_ok_ff, char_ok_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic [ADDR_W-1:0] row_base_ff, row_base_in;
   logic              changed_ff, changed_in;
   logic              need_cur_ff, need_cur_in;
   logic [POS_W-1:0]  scan_col_ff, scan_col_in;
   logic [COL_W-1:0]  qcol_ff, qcol_in;
   logic              any_ff, any_in;
   logic [COL_W-1:0]  first_ff, first_in;
   logic [COL_W-1:0]  last_pos_ff, last_pos_in;
   logic [COL_W-1:0]  pad_col_ff, pad_col_in;
   rsp_item_type      rsp_item_ff, rsp_item_in;

   // Memory port signals
   logic              changed_now;
   logic              scan_issue;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [ADDR_W-1:0] acc_addr;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [7:0]        wr_data;

   assign rd_data = vld_q_ff ? mem_q_ff : SPACE_CHAR;

   // Position of the incoming item
   always_comb begin
      in_range_in = (int'(req_item.row_index) < ROWS) &&
                    (int'(req_item.start_column) < COLUMNS);
      pos_in      = POS_W'(req_item.start_column) + POS_W'(offset_ff);
      char_ok_in  = in_range_in && req_item.char_present && (int'(pos_in) < COLUMNS);
      row_base_in = ADDR_W'(int'(req_item.row_index) * COLUMNS);
      acc_addr    = char_ok_in ? (row_base_in + ADDR_W'(pos_in)) : '0;
      idx_in      = acc_addr;
   end

   // Read and write port selection
   always_comb begin
      changed_now = char_ok_ff && (item_ff.force_write || (rd_data != item_ff.char_code));
      scan_issue  = cmd.scan_step && (int'(scan_col_ff) < COLUMNS);
      rd_en       = cmd.accept || scan_issue;
      rd_addr     = cmd.accept ? acc_addr : (row_base_ff + ADDR_W'(scan_col_ff));
      wr_en       = (cmd.compare && changed_now) ||
                    (cmd.load_out && (cmd.out_sel == SEL_PAD_SP));
      wr_addr     = cmd.compare ? idx_ff : (row_base_ff + ADDR_W'(pad_col_ff));
      wr_data     = cmd.compare ? item_ff.char_code : SPACE_CHAR;
   end

   // Next values of the working registers
   always_comb begin
      valid_in     = valid_ff;
      offset_in    = offset_ff;
      prev_in      = prev_ff;
      item_in      = item_ff;
      changed_in   = changed_ff;
      need_cur_in  = need_cur_ff;
      scan_col_in  = scan_col_ff;
      scan_pend_in = scan_issue;
      qcol_in      = qcol_ff;
      any_in       = any_ff;
      first_in     = first_ff;
      last_pos_in  = last_pos_ff;
      pad_col_in   = pad_col_ff;

      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end

      if (cmd.accept) begin
         item_in = req_item;
         any_in  = 1'b0;
      end

      // Character decision and write-position bookkeeping
      if (cmd.compare) begin
         changed_in  = changed_now;
         need_cur_in = !prev_ff;
         scan_col_in = pos_ff + POS_W'(char_ok_ff);
         if (item_ff.last_char) begin
            offset_in = '0;
            prev_in   = 1'b0;
         end else if (char_ok_ff) begin
            offset_in = offset_ff + OFF_W'(1);
            prev_in   = changed_now;
         end
      end

      // Scan issue side
      if (scan_issue) begin
         qcol_in     = COL_W'(scan_col_ff);
         scan_col_in = scan_col_ff + POS_W'(1);
      end

      // Scan compare side, one entry behind the issue
      if (scan_pend_ff && (rd_data != SPACE_CHAR)) begin
         if (!any_ff) begin
            first_in = qcol_ff;
         end
         any_in      = 1'b1;
         last_pos_in = qcol_ff;
      end

      // Padding walk
      if (cmd.load_out && (cmd.out_sel == SEL_PAD_CUR)) begin
         pad_col_in = first_ff;
      end else if (cmd.load_out && (cmd.out_sel == SEL_PAD_SP)) begin
         pad_col_in = pad_col_ff + COL_W'(1);
      end
   end

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_item_in  = rsp_item_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
         rsp_item_in  = '0;
         case (cmd.out_sel)
            SEL_CH_CUR: begin
               rsp_item_in.cmd_kind = KIND_CURSOR;
               rsp_item_in.out_col  = 5'(pos_ff);
               rsp_item_in.out_row  = item_ff.row_index[1:0];
            end
            SEL_CH_WR: begin
               rsp_item_in.cmd_kind     = KIND_WRITE;
               rsp_item_in.out_char     = item_ff.char_code;
               rsp_item_in.last_of_item = !any_ff;
            end
            SEL_PAD_CUR: begin
               rsp_item_in.cmd_kind = KIND_CURSOR;
               rsp_item_in.out_col  = 5'(first_ff);
               rsp_item_in.out_row  = item_ff.row_index[1:0];
            end
            SEL_PAD_SP: begin
               rsp_item_in.cmd_kind     = KIND_WRITE;
               rsp_item_in.out_char     = SPACE_CHAR;
               rsp_item_in.last_of_item = (pad_col_ff == last_pos_ff);
            end
            default: begin
               rsp_item_in = '0;
            end
         endcase
      end
   end

   // Shadow memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         mem_q_ff <= mem[rd_addr];
         vld_q_ff <= valid_ff[rd_addr];
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         offset_ff    <= '0;
         prev_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         scan_pend_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         offset_ff    <= offset_in;
         prev_ff      <= prev_in;
         rsp_valid_ff <= rsp_valid_in;
         scan_pend_ff <= scan_pend_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         in_range_ff <= in_range_in;
         char_ok_ff  <= char_ok_in;
         pos_ff      <= pos_in;
         idx_ff      <= idx_in;
         row_base_ff <= row_base_in;
      end
      item_ff     <= item_in;
      changed_ff  <= changed_in;
      need_cur_ff <= need_cur_in;
      scan_col_ff <= scan_col_in;
      qcol_ff     <= qcol_in;
      any_ff      <= any_in;
      first_ff    <= first_in;
      last_pos_ff <= last_pos_in;
      pad_col_ff  <= pad_col_in;
      rsp_item_ff <= rsp_item_in;
   end

   // Status toward the controller
   always_comb begin
      status.changed_now = changed_now;
      status.changed     = changed_ff;
      status.need_cursor = need_cur_ff;
      status.last        = item_ff.last_char;
      status.in_range    = in_range_ff;
      status.any_pad     = any_ff;
      status.scan_busy   = (int'(scan_col_ff) < COLUMNS) || scan_pend_ff;
      status.pad_end     = (pad_col_ff == last_pos_ff);
      status.out_free    = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

// File: sv/sdw_ctrl.sv
`include "char_lcd_shadow_diff_writer_core_defines.svh"

module sdw_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output sdw_pkg::cmd_type    cmd,
   input  sdw_pkg::status_type status
);
   import sdw_pkg::*;

   state_type state_ff, state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && !reset) begin
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            if (status.last && status.in_range) begin
               state_in = ST_SCAN;
            end else if (status.changed_now) begin
               state_in = ST_CH_CUR;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (!status.scan_busy) begin
               if (status.changed) begin
                  state_in = ST_CH_CUR;
               end else if (status.any_pad) begin
                  state_in = ST_PAD_CUR;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_CH_CUR: begin
            if (!status.need_cursor || status.out_free) begin
               state_in = ST_CH_WR;
            end
         end
         ST_CH_WR: begin
            if (status.out_free) begin
               state_in = status.any_pad ? ST_PAD_CUR : ST_IDLE;
            end
         end
         ST_PAD_CUR: begin
            if (status.out_free) begin
               state_in = ST_PAD_SP;
            end
         end
         ST_PAD_SP: begin
            if (status.out_free && status.pad_end) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Commands
   always_comb begin
      req_ready     = 1'b0;
      cmd.accept    = 1'b0;
      cmd.compare   = 1'b0;
      cmd.scan_step = 1'b0;
      cmd.load_out  = 1'b0;
      cmd.out_sel   = SEL_CH_CUR;
      case (state_ff)
         ST_IDLE: begin
            req_ready  = !reset;
            cmd.accept = req_valid && !reset;
         end
         ST_CMP: begin
            cmd.compare = 1'b1;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
         end
         ST_CH_CUR: begin
            cmd.load_out = status.need_cursor && status.out_free;
            cmd.out_sel  = SEL_CH_CUR;
         end
         ST_CH_WR: begin
            cmd.load_out = status.out_free;
            cmd.out_sel  = SEL_CH_WR;
         end
         ST_PAD_CUR: begin
            cmd.load_out = status.out_free;
            cmd.out_sel  = SEL_PAD_CUR;
         end
         ST_PAD_SP: begin
            cmd.load_out = status.out_free;
            cmd.out_sel  = SEL_PAD_SP;
         end
         default: begin
            cmd.load_out = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Checks
   `SDW_ASSERT(a_load_when_free, cmd.load_out |-> status.out_free, "result loaded over a held result")
   `SDW_ASSERT(a_pad_needs_any, (state_ff == ST_PAD_SP) |-> status.any_pad, "padding without a non-space entry")
   `SDW_ASSERT(a_write_needs_change, (state_ff == ST_CH_WR) |-> status.changed, "character emitted but unchanged")
   `SDW_ASSERT_NEXT(a_cmp_after_accept, cmd.accept, (state_ff == ST_CMP), "accepted item not compared")

endmodule

// File: sv/char_lcd_shadow_diff_writer_core.sv
// Shadow-copy diff writer for a 4 x 20 character display.
// req_chan carries one text character per item (row, start column, force and
// last marks); an item with char_present low and last_char high is an empty
// write. rsp_chan carries set-cursor and write-character commands; the final
// command caused by an item has last_of_item set.
// Order: an accepted item is compared against the shadow, then any cursor and
// write commands are loaded into the output register; an unchanged character
// emits no write. A last item adds a walk of the rest of the row, one
// shadow entry per cycle through the single read port, then padding commands
// that fill the span from the first to the last non-space entry with spaces.
// One item is worked on at a time; req_chan.ready is high only between items.
// Reset: synchronous; the shadow reads as all spaces at once (per-entry
// written marks are cleared), with no clearing pass, and the write position
// returns to the start.
// A stalled receiver holds the command in the output register; the block
// waits in place and resumes when rsp_chan.ready returns.
module char_lcd_shadow_diff_writer_core (
   input logic      clock,
   input logic      reset,
   sdw_req_if.sink   req_chan,
   sdw_rsp_if.source rsp_chan
);
   import sdw_pkg::*;

   cmd_type      cmd;
   status_type   status;
   logic         req_ready;
   logic         rsp_valid;
   rsp_item_type rsp_item;

   sdw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .status    (status)
   );

   sdw_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_chan.item),
      .cmd       (cmd),
      .status    (status),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   assign req_chan.ready = req_ready;
   assign rsp_chan.valid = rsp_valid;
   assign rsp_chan.item  = rsp_item;

endmodule
